// File: rtl/core/lldq_pkg.sv
`default_nettype none

package lldq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int FUNC_W       = 3;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT   = 3'd0,
		FN_DELKEY   = 3'd1,
		FN_DELFIRST = 3'd2,
		FN_DELLAST  = 3'd3,
		FN_DUMP     = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage

`default_nettype wire

// File: rtl/core/linked_list_deque_with_key_delete_core.sv
`default_nettype none

// Doubly linked list of signed 32-bit keys in CAPACITY slots, with a free pool.
// Request channel: func/key are taken at a rising edge with start high and busy
// low. func: insert front, delete key, delete first, delete last, dump.
// Result channel: value/last/status/count are shown for one cycle with valid
// high; there is no back-pressure, the receiver must take every result.
// Each non-dump request gives one result with last set; dump gives one result
// per entry, front to back, last on the final one (one empty result if none).
// Steps, request accepted to first result:
//   immediate cases (empty list, full store, unused func code): answered from idle
//   insert: S_INS_A, then S_INS_B; delete first/last: S_WALK, S_UNL1, S_UNL2
//   delete key: S_WALK follows links from the front to the match, then S_UNL1,
//     S_UNL2; with no match the walk ends at the back with status missing
//   dump: S_DUMP gives one result per cycle
// The slot store is a single-port-write, registered-read memory; walks follow
// one link per cycle, so delete key and dump are bounded by the list length.
// busy stays high until the last result goes out; the next request may be
// accepted in the cycle that result is shown.
// Reset empties the list and free pool at once; no clearing pass is needed.
module linked_list_deque_with_key_delete_core #(
	parameter int CAPACITY = lldq_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic        [lldq_pkg::FUNC_W-1:0]  func,
	input  wire logic signed [lldq_pkg::KEY_W-1:0]   key,
	output logic                                     valid,
	output logic signed      [lldq_pkg::KEY_W-1:0]   value,
	output logic                                     last,
	output logic             [lldq_pkg::STATUS_W-1:0] status,
	output logic             [lldq_pkg::COUNT_W-1:0]  count
);
	import lldq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IW-1:0]    nxt;
		logic [IW-1:0]    prv;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_A,
		S_INS_B,
		S_WALK,
		S_DUMP,
		S_UNL1,
		S_UNL2
	} state_t;

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic             del_any_q;
	logic [IW-1:0]    cur_q;
	logic [CW-1:0]    pos_q;
	logic [IW-1:0]    head_q;
	logic [IW-1:0]    tail_q;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    alloc_q;
	logic [IW-1:0]    nx_q;
	logic [IW-1:0]    pv_q;
	logic             first_q;
	logic             endpos_q;

	logic                    valid_q;
	logic signed [KEY_W-1:0] value_q;
	logic                    last_q;
	status_t                 status_q;
	logic [COUNT_W-1:0]      count_q;

	slot_t         slot_mem [CAPACITY];
	slot_t         rd_q;
	slot_t         wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;

	logic          accept;
	logic          match;
	logic          at_end;
	logic          empty;
	logic [IW-1:0] pool_slot;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign match  = del_any_q || (rd_q.key == key_q);
	assign at_end = ((pos_q + CW'(1)) == cnt_q);
	assign empty  = (cnt_q == '0);

	assign valid  = valid_q;
	assign value  = value_q;
	assign last   = last_q;
	assign status = status_q;
	assign count  = count_q;

	lldq_free_pool #(
		.CAPACITY (CAPACITY)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.peek      (accept && (func_t'(func) == FN_INSERT)),
		.take      (state_q == S_INS_A),
		.push      ((state_q == S_WALK) && match),
		.push_slot (cur_q),
		.slot      (pool_slot)
	);

	// slot store port control; rd_q always holds the entry the current state works on
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = rd_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = 1'b1;
				rd_addr = (func_t'(func) == FN_DELLAST) ? tail_q : head_q;
			end
			S_INS_A: begin
				wr_en       = !empty;
				wr_addr     = head_q;
				wr_data.prv = pool_slot;
			end
			S_INS_B: begin
				wr_en       = 1'b1;
				wr_addr     = alloc_q;
				wr_data.key = key_q;
				wr_data.nxt = head_q;
				wr_data.prv = '0;
			end
			S_WALK: begin
				// on a hit fetch the predecessor for relinking
				rd_en   = 1'b1;
				rd_addr = match ? rd_q.prv : rd_q.nxt;
			end
			S_DUMP: begin
				rd_en   = 1'b1;
				rd_addr = rd_q.nxt;
			end
			S_UNL1: begin
				wr_en       = !first_q;
				wr_addr     = pv_q;
				wr_data.nxt = nx_q;
				rd_en       = 1'b1;
				rd_addr     = nx_q;
			end
			S_UNL2: begin
				wr_en       = !endpos_q;
				wr_addr     = nx_q;
				wr_data.prv = pv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			key_q     <= '0;
			del_any_q <= 1'b0;
			cur_q     <= '0;
			pos_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			alloc_q   <= '0;
			nx_q      <= '0;
			pv_q      <= '0;
			first_q   <= 1'b0;
			endpos_q  <= 1'b0;
			valid_q   <= 1'b0;
			value_q   <= '0;
			last_q    <= 1'b0;
			status_q  <= ST_DONE;
			count_q   <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q     <= key;
						del_any_q <= 1'b0;
						cur_q     <= head_q;
						pos_q     <= '0;
						value_q   <= '0;
						last_q    <= 1'b1;
						count_q   <= COUNT_W'(cnt_q);
						case (func_t'(func)) inside
							FN_INSERT: begin
								if (cnt_q == CAP_C) begin
									valid_q  <= 1'b1;
									status_q <= ST_FULL;
								end else begin
									state_q <= S_INS_A;
								end
							end
							FN_DELKEY, FN_DELFIRST, FN_DELLAST, FN_DUMP: begin
								if (empty) begin
									valid_q  <= 1'b1;
									status_q <= ST_EMPTY;
								end else if (func_t'(func) == FN_DUMP) begin
									state_q <= S_DUMP;
								end else begin
									state_q   <= S_WALK;
									del_any_q <= (func_t'(func) != FN_DELKEY);
									if (func_t'(func) == FN_DELLAST) begin
										cur_q <= tail_q;
										pos_q <= cnt_q - CW'(1);
									end
								end
							end
							default: begin
								valid_q  <= 1'b1;
								status_q <= ST_DONE;
							end
						endcase
					end
				end
				S_INS_A: begin
					alloc_q <= pool_slot;
					state_q <= S_INS_B;
				end
				S_INS_B: begin
					head_q <= alloc_q;
					if (empty)
						tail_q <= alloc_q;
					cnt_q    <= cnt_q + CW'(1);
					valid_q  <= 1'b1;
					status_q <= ST_DONE;
					count_q  <= COUNT_W'(cnt_q + CW'(1));
					state_q  <= S_IDLE;
				end
				S_WALK: begin
					if (match) begin
						nx_q     <= rd_q.nxt;
						pv_q     <= rd_q.prv;
						first_q  <= (pos_q == '0);
						endpos_q <= at_end;
						state_q  <= S_UNL1;
					end else if (at_end) begin
						valid_q  <= 1'b1;
						status_q <= ST_MISSING;
						state_q  <= S_IDLE;
					end else begin
						cur_q <= rd_q.nxt;
						pos_q <= pos_q + CW'(1);
					end
				end
				S_DUMP: begin
					valid_q  <= 1'b1;
					value_q  <= rd_q.key;
					last_q   <= at_end;
					status_q <= ST_DONE;
					pos_q    <= pos_q + CW'(1);
					if (at_end)
						state_q <= S_IDLE;
				end
				S_UNL1: begin
					state_q <= S_UNL2;
				end
				S_UNL2: begin
					if (first_q)
						head_q <= nx_q;
					if (endpos_q)
						tail_q <= pv_q;
					cnt_q    <= cnt_q - CW'(1);
					valid_q  <= 1'b1;
					status_q <= ST_DONE;
					count_q  <= COUNT_W'(cnt_q - CW'(1));
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_end_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (valid && last))
		else $error("core: request finished without a final result");
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || valid))
		else $error("core: accepted request neither worked on nor answered");
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (status == ST_EMPTY)) |-> (count == '0))
		else $error("core: empty status with nonzero count");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("core: entry count beyond capacity");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lldq_free_pool.sv
`default_nettype none

module lldq_free_pool #(
	parameter int CAPACITY = lldq_pkg::CAPACITY_DEF,
	localparam int IW = $clog2(CAPACITY)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          peek,
	input  wire logic          take,
	input  wire logic          push,
	input  wire logic [IW-1:0] push_slot,
	output logic      [IW-1:0] slot
);
	import lldq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// slots below fresh_q have been handed out at least once; recycled ones sit on the stack
	logic [CW-1:0] fresh_q;
	logic [CW-1:0] ftop_q;
	logic [CW-1:0] ftop_dec;
	logic          fresh_left;
	logic [IW-1:0] free_mem [CAPACITY];
	logic [IW-1:0] rd_q;

	assign fresh_left = (fresh_q != CAP_C);
	assign ftop_dec   = ftop_q - CW'(1);
	assign slot       = fresh_left ? fresh_q[IW-1:0] : rd_q;

	always_ff @(posedge clk) begin
		if (push)
			free_mem[ftop_q[IW-1:0]] <= push_slot;
		if (peek)
			rd_q <= free_mem[ftop_dec[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			ftop_q  <= '0;
		end else begin
			if (take && fresh_left)
				fresh_q <= fresh_q + CW'(1);
			if (take && !fresh_left)
				ftop_q <= ftop_dec;
			else if (push)
				ftop_q <= ftop_q + CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_take_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && push))
		else $error("free pool: take and push together");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (ftop_q < CAP_C))
		else $error("free pool: push onto full stack");
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (fresh_left || (ftop_q != '0)))
		else $error("free pool: take with no free slot");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lldq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	// func codes the block does not use; it must answer them and change nothing
	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [KEY_W-1:0] value;
		logic                    last;
		status_t                 status;
		logic [COUNT_W-1:0]      count;
	} result_t;

	typedef struct {
		logic [FUNC_W-1:0]       func;
		logic signed [KEY_W-1:0] key;
		logic                    typed;
		status_t                 status;
		logic [COUNT_W-1:0]      count;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [FUNC_W-1:0] func;
	logic signed [KEY_W-1:0] key;
	logic valid;
	logic signed [KEY_W-1:0] value;
	logic last;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0] count;

	logic signed [KEY_W-1:0] list_keys[$];	// front of the list at index 0
	result_t   due_results[$];
	plan_row_t plan[$];
	int unsigned mismatches = 0;
	int unsigned issued = 0;
	bit gaps_on = 1'b1;

	linked_list_deque_with_key_delete_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.func   (func),
		.key    (key),
		.valid  (valid),
		.value  (value),
		.last   (last),
		.status (status),
		.count  (count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic void predict_list_op(input logic [FUNC_W-1:0] f,
			input logic signed [KEY_W-1:0] k, output result_t outs[$]);
		result_t r;
		int hit;
		outs = {};
		r.value = '0;
		r.last = 1'b1;
		r.status = ST_DONE;
		hit = -1;
		case (f)
			FN_INSERT: begin
				if (list_keys.size() >= CAP)
					r.status = ST_FULL;
				else
					list_keys.push_front(k);
			end
			FN_DELKEY: begin
				if (list_keys.size() == 0)
					r.status = ST_EMPTY;
				else begin
					for (int i = 0; i < list_keys.size() && hit < 0; i++)
						if (list_keys[i] == k)
							hit = i;
					if (hit < 0)
						r.status = ST_MISSING;
					else
						list_keys.delete(hit);
				end
			end
			FN_DELFIRST: begin
				if (list_keys.size() == 0)
					r.status = ST_EMPTY;
				else
					void'(list_keys.pop_front());
			end
			FN_DELLAST: begin
				if (list_keys.size() == 0)
					r.status = ST_EMPTY;
				else
					void'(list_keys.pop_back());
			end
			FN_DUMP: begin
				if (list_keys.size() == 0)
					r.status = ST_EMPTY;
				else begin
					for (int i = 0; i < list_keys.size(); i++) begin
						r.value = list_keys[i];
						r.last = (i == list_keys.size() - 1);
						r.count = COUNT_W'(list_keys.size());
						outs.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(list_keys.size());
		outs.push_back(r);
	endfunction

	// one request; results are predicted at the edge that accepts it
	task automatic send_request(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k,
			input logic typed = 1'b0, input status_t st = ST_DONE,
			input logic [COUNT_W-1:0] cnt = '0);
		result_t outs[$];
		result_t fixed;
		if (gaps_on)
			while ($urandom_range(99) < 35) begin
				start <= 1'b0;
				func <= FUNC_W'($urandom);
				key <= $urandom;
				@(posedge clk);
			end
		start <= 1'b1;
		func <= f;
		key <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_list_op(f, k, outs);
		if (typed) begin
			fixed.value = '0;
			fixed.last = 1'b1;
			fixed.status = st;
			fixed.count = cnt;
			due_results.push_back(fixed);
		end else
			foreach (outs[i])
				due_results.push_back(outs[i]);
		issued++;
	endtask

	// small pool so that delete-key finds matches and duplicates occur
	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return $signed($urandom_range(15)) - 8;
		else if (r < 50)
			return ($urandom_range(1) != 0) ? KEY_MAX : KEY_MIN;
		else
			return $urandom;
	endfunction

	function automatic logic [FUNC_W-1:0] choose_func(input int mode);
		int unsigned r;
		int ins_w;
		int dk_w;
		r = $urandom_range(99);
		case (mode)
			0: begin ins_w = 60; dk_w = 72; end
			1: begin ins_w = 20; dk_w = 50; end
			default: begin ins_w = 40; dk_w = 62; end
		endcase
		if (r < ins_w)
			return FN_INSERT;
		else if (r < dk_w)
			return FN_DELKEY;
		else if (r < dk_w + (100 - dk_w) * 3 / 8)
			return FN_DELFIRST;
		else if (r < dk_w + (100 - dk_w) * 6 / 8)
			return FN_DELLAST;
		else if (r < 97)
			return FN_DUMP;
		else
			return FUNC_W'($urandom_range(FN_SPARE_C, FN_SPARE_A));
	endfunction

	always @(posedge clk) begin
		result_t w;
		if (arst_n && valid) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: value %0d last %0d status %0d count %0d",
					value, last, status, count);
				mismatches++;
			end else begin
				w = due_results.pop_front();
				if (value !== w.value) begin
					$error("value: expected %0d, got %0d", w.value, value);
					mismatches++;
				end
				if (last !== w.last) begin
					$error("last: expected %0d, got %0d", w.last, last);
					mismatches++;
				end
				if (status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, status);
					mismatches++;
				end
				if (count !== w.count) begin
					$error("count: expected %0d, got %0d", w.count, count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [FUNC_W-1:0] f;
		logic signed [KEY_W-1:0] k;
		int mode;
		int waited;
		bit present;

		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FN_INSERT;
		key <= '0;

		// empty list, spare codes, extremes, duplicates, deletes at both ends
		plan.push_back('{FN_DUMP, 0, 1'b1, ST_EMPTY, 7'd0});
		plan.push_back('{FN_DELFIRST, 0, 1'b1, ST_EMPTY, 7'd0});
		plan.push_back('{FN_DELLAST, -1, 1'b1, ST_EMPTY, 7'd0});
		plan.push_back('{FN_DELKEY, 5, 1'b1, ST_EMPTY, 7'd0});
		plan.push_back('{FN_SPARE_A, -1, 1'b1, ST_DONE, 7'd0});
		plan.push_back('{FN_SPARE_B, KEY_MAX, 1'b1, ST_DONE, 7'd0});
		plan.push_back('{FN_SPARE_C, KEY_MIN, 1'b1, ST_DONE, 7'd0});
		plan.push_back('{FN_INSERT, KEY_MIN, 1'b1, ST_DONE, 7'd1});
		plan.push_back('{FN_INSERT, KEY_MAX, 1'b1, ST_DONE, 7'd2});
		plan.push_back('{FN_INSERT, -1, 1'b1, ST_DONE, 7'd3});
		plan.push_back('{FN_INSERT, 0, 1'b1, ST_DONE, 7'd4});
		plan.push_back('{FN_INSERT, KEY_MAX, 1'b1, ST_DONE, 7'd5});
		plan.push_back('{FN_DUMP, 0, 1'b0, ST_DONE, 7'd0});
		plan.push_back('{FN_DELKEY, 12345, 1'b1, ST_MISSING, 7'd5});
		plan.push_back('{FN_DELKEY, KEY_MAX, 1'b1, ST_DONE, 7'd4});
		plan.push_back('{FN_DUMP, -1, 1'b0, ST_DONE, 7'd0});
		plan.push_back('{FN_DELKEY, KEY_MIN, 1'b1, ST_DONE, 7'd3});
		plan.push_back('{FN_DELFIRST, 0, 1'b1, ST_DONE, 7'd2});
		plan.push_back('{FN_DELLAST, 0, 1'b1, ST_DONE, 7'd1});
		plan.push_back('{FN_SPARE_A, 0, 1'b1, ST_DONE, 7'd1});
		plan.push_back('{FN_DUMP, 0, 1'b0, ST_DONE, 7'd0});
		plan.push_back('{FN_DELKEY, -1, 1'b1, ST_DONE, 7'd0});
		plan.push_back('{FN_DUMP, 0, 1'b1, ST_EMPTY, 7'd0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_request(plan[i].func, plan[i].key, plan[i].typed, plan[i].status,
				plan[i].count);

		// fill the store, push past full, walk the whole list, then search it end to end
		while (list_keys.size() < CAP)
			send_request(FN_INSERT, pick_key());
		repeat (3)
			send_request(FN_INSERT, pick_key());
		send_request(FN_DUMP, $urandom);
		send_request(FN_DELKEY, list_keys[CAP-1]);
		do begin
			k = $urandom;
			present = 1'b0;
			foreach (list_keys[i])
				if (list_keys[i] == k)
					present = 1'b1;
		end while (present);
		send_request(FN_DELKEY, k);

		while (issued < 380) begin
			if (issued % 40 == 0)
				mode = $urandom_range(2);
			gaps_on = !(issued >= 200 && issued < 290);
			f = choose_func(mode);
			if (f == FN_DELKEY && list_keys.size() != 0 && $urandom_range(99) < 60)
				k = list_keys[$urandom_range(list_keys.size() - 1)];
			else
				k = pick_key();
			send_request(f, k);
		end
		start <= 1'b0;

		waited = 0;
		while (due_results.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d expected results never arrived", due_results.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: linked_list_deque_with_key_delete_core.f
rtl/core/lldq_pkg.sv
rtl/core/lldq_free_pool.sv
rtl/core/linked_list_deque_with_key_delete_core.sv
test/testbench.sv
